### hdl/dkst_pkg.sv
// dkst_pkg: shared types and constants of the descrambler key slot table
// sizes, command and outcome codes, sequencer states, pid map entry layout
// no dependencies
package dkst_pkg;

  localparam int KEY_SLOTS = 16;
  localparam int PID_SLOTS = 8;

  localparam int PID_W     = 13;
  localparam int KEY_W     = 64;
  localparam int SLOT_W    = $clog2(KEY_SLOTS);
  localparam int PID_IDX_W = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;
  localparam int SCAN_W    = $clog2(PID_SLOTS + 1);
  localparam int CNT_W     = $clog2(PID_SLOTS + 1);

  localparam logic [1:0] BIT_EVEN   = 2'b10;
  localparam logic [1:0] BIT_ODD    = 2'b01;
  localparam logic [1:0] BOTH_READY = 2'b11;

  typedef enum logic [2:0] {
    CMD_INVALIDATE = 3'd0,
    CMD_ADD_PID    = 3'd1,
    CMD_CLOSE_PID  = 3'd2,
    CMD_EVEN_KEY   = 3'd3,
    CMD_ODD_KEY    = 3'd4,
    CMD_NEXUS      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_IGNORED  = 2'd0,
    OUT_APPLIED  = 2'd1,
    OUT_MAP_FULL = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [SLOT_W-1:0] slot;
  } pid_entry_t;

endpackage

### hdl/descrambler_key_slot_table.sv
// descrambler_key_slot_table: key slot table and pid map of a stream descrambler
// pid map and control words held in synchronous memories, slot flags in flip-flops
// depends on dkst_pkg
//
// Usage: one command beat in on the s_ group, one result beat out on the m_ group.
// s_tuser carries the command code, s_tdata the slot index, the pid and the
// 64-bit control word. m_tdata returns the outcome, the scramble mode, the ready
// and pending bits of the addressed slot, the nexus flag and the mapped pid count.
// Add-pid and close-pid with a slot in range walk the pid map memory one entry per
// cycle through its registered read port before the command executes, and the
// result then passes through the output register onto m_tdata. Every other beat
// skips the walk and goes straight to execution.
// One command is in work at a time; s_tready is high only between commands.
// The result sits in an output register: a new command is taken while it waits,
// and only a second result waits for m_tready.
// Reset (rst, synchronous) empties the pid map, clears all slot flags, the mode
// and the nexus flag at once; stored control words stay undefined until written.
module descrambler_key_slot_table
  import dkst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // slot_index[5:0], stream_pid[18:6], key_value[82:19], zero
  input  logic [2:0]  s_tuser,  // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // outcome, scramble_mode, slot_ready_bits,
                                // slot_pending_bits, nexus_flag, mapped_pid_count, zero
);

  state_t state, state_next;

  // command registers
  cmd_t              cmd_r;
  logic              have_slot;
  logic [SLOT_W-1:0] slot_r;
  logic [PID_W-1:0]  pid_r;
  logic [KEY_W-1:0]  key_r;

  // pid map
  pid_entry_t           pid_mem [PID_SLOTS];
  pid_entry_t           rd_data;
  logic [PID_SLOTS-1:0] used;
  logic [SCAN_W-1:0]    scan_cnt;
  logic [PID_IDX_W-1:0] cmp_idx;
  logic                 hit;
  logic [PID_IDX_W-1:0] hit_idx;
  logic [SLOT_W-1:0]    hit_slot;
  logic                 free_found;
  logic [PID_IDX_W-1:0] free_idx;

  // key slots
  logic [KEY_W-1:0]     key_mem [2*KEY_SLOTS];
  logic [KEY_SLOTS-1:0] slot_valid;
  logic [1:0]           slot_ready   [KEY_SLOTS];
  logic [1:0]           slot_pending [KEY_SLOTS];
  logic [CNT_W-1:0]     slot_refs    [KEY_SLOTS];
  logic                 mode;
  logic                 nexus;
  logic [CNT_W-1:0]     pid_count;

  // result
  outcome_t          outcome_r;
  logic [SLOT_W-1:0] rslot;

  logic       in_range;
  logic       scan_rd;
  logic       scan_cmp;
  logic       exec;
  logic       load_out;
  logic       slot_mapped;
  logic [1:0] key_b;
  logic [1:0] ready_new;
  logic       pid_we;
  logic       key_we;
  logic [6:0] cnt_ext;
  logic [3:0] cnt_sat;

  assign in_range    = !s_tdata[5] && ({1'b0, s_tdata[5:0]} < 7'(KEY_SLOTS));
  assign cmp_idx     = PID_IDX_W'(scan_cnt - SCAN_W'(1));
  assign slot_mapped = (slot_refs[slot_r] != '0);
  assign key_b       = (cmd_r == CMD_EVEN_KEY) ? BIT_EVEN : BIT_ODD;
  assign ready_new   = slot_ready[slot_r] | key_b;
  assign pid_we      = exec && have_slot && (cmd_r == CMD_ADD_PID) && !hit && free_found;
  assign key_we      = exec && have_slot && slot_mapped
                       && ((cmd_r == CMD_EVEN_KEY) || (cmd_r == CMD_ODD_KEY));
  assign cnt_ext     = 7'(pid_count);
  assign cnt_sat     = (cnt_ext > 7'd15) ? 4'd15 : cnt_ext[3:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_range && ((s_tuser == CMD_ADD_PID) || (s_tuser == CMD_CLOSE_PID))) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_W'(PID_SLOTS)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC:   state_next = ST_RESULT;
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    scan_rd  = (state == ST_SCAN) && (scan_cnt < SCAN_W'(PID_SLOTS));
    scan_cmp = (state == ST_SCAN) && (scan_cnt != '0);
    exec     = (state == ST_EXEC);
    load_out = (state == ST_RESULT) && (!m_tvalid || m_tready);
  end

  // pid map memory
  always_ff @(posedge clk) begin
    if (pid_we) begin
      pid_mem[free_idx] <= '{pid: pid_r, slot: slot_r};
    end
    if (scan_rd) begin
      rd_data <= pid_mem[scan_cnt[PID_IDX_W-1:0]];
    end
  end

  // control word memory, even and odd words side by side
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[{slot_r, (cmd_r == CMD_ODD_KEY)}] <= key_r;
    end
  end

  // command capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_r     <= cmd_t'(s_tuser);
      have_slot <= in_range;
      slot_r    <= SLOT_W'(s_tdata[4:0]);
      pid_r     <= s_tdata[18:6];
      key_r     <= s_tdata[82:19];
    end
    if (state == ST_SCAN && scan_cnt != SCAN_W'(PID_SLOTS)) begin
      scan_cnt <= scan_cnt + SCAN_W'(1);
    end else if (s_tvalid && s_tready) begin
      scan_cnt <= '0;
    end
    if (s_tvalid && s_tready) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (scan_cmp) begin
      if (!hit && used[cmp_idx] && (rd_data.pid == pid_r)) begin
        hit      <= 1'b1;
        hit_idx  <= cmp_idx;
        hit_slot <= rd_data.slot;
      end
      if (!free_found && !used[cmp_idx]) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
  end

  // table state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      slot_valid <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slot_ready[i]   <= '0;
        slot_pending[i] <= '0;
        slot_refs[i]    <= '0;
      end
      mode      <= 1'b0;
      nexus     <= 1'b0;
      pid_count <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;

      if (exec) begin
        outcome_r <= OUT_IGNORED;
        rslot     <= slot_r;
        if (have_slot) begin
          case (cmd_r)
            CMD_INVALIDATE: begin
              mode       <= 1'b0;
              slot_valid <= '0;
              used       <= '0;
              pid_count  <= '0;
              for (int i = 0; i < KEY_SLOTS; i++) begin
                slot_refs[i] <= '0;
              end
              outcome_r <= OUT_APPLIED;
            end
            CMD_ADD_PID: begin
              if (!hit) begin
                if (!free_found) begin
                  outcome_r <= OUT_MAP_FULL;
                end else begin
                  if (!slot_valid[slot_r]) begin
                    slot_valid[slot_r]   <= 1'b1;
                    slot_ready[slot_r]   <= '0;
                    slot_pending[slot_r] <= '0;
                  end
                  used[free_idx]    <= 1'b1;
                  pid_count         <= pid_count + CNT_W'(1);
                  slot_refs[slot_r] <= slot_refs[slot_r] + CNT_W'(1);
                  outcome_r         <= OUT_APPLIED;
                end
              end
            end
            CMD_CLOSE_PID: begin
              if (hit) begin
                rslot               <= hit_slot;
                used[hit_idx]       <= 1'b0;
                pid_count           <= pid_count - CNT_W'(1);
                slot_refs[hit_slot] <= slot_refs[hit_slot] - CNT_W'(1);
                if (slot_refs[hit_slot] == CNT_W'(1)) begin
                  slot_ready[hit_slot] <= '0;
                end
                if (pid_count == CNT_W'(1)) begin
                  mode <= 1'b0;
                end
                outcome_r <= OUT_APPLIED;
              end
            end
            CMD_EVEN_KEY, CMD_ODD_KEY: begin
              if (slot_mapped) begin
                slot_ready[slot_r]   <= ready_new;
                slot_pending[slot_r] <= slot_pending[slot_r] | key_b;
                if (!mode && (ready_new == BOTH_READY)) begin
                  mode <= 1'b1;
                end
                outcome_r <= OUT_APPLIED;
              end
            end
            CMD_NEXUS: begin
              if (slot_mapped) begin
                nexus     <= 1'b1;
                mode      <= 1'b1;
                outcome_r <= OUT_APPLIED;
              end
            end
            default: begin
              outcome_r <= OUT_IGNORED;
            end
          endcase
        end
      end

      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'd0,
                  cnt_sat,
                  nexus,
                  have_slot ? slot_pending[rslot] : 2'b00,
                  have_slot ? slot_ready[rslot] : 2'b00,
                  mode,
                  outcome_r};
    end
  end

endmodule

### verif/dkst_checker.sv
`timescale 1ns / 1ps
// dkst_checker: predicts and checks the result beats of the key slot table
// keeps its own copy of the pid map and slot flags, compares beats field by field
// depends on dkst_pkg
module dkst_checker
  import dkst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,  // slot_index[5:0], stream_pid[18:6], key_value[82:19], zero
  input  logic [2:0]  s_tuser,  // cmd[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,  // outcome, scramble_mode, slot_ready_bits,
                                // slot_pending_bits, nexus_flag, mapped_pid_count, zero
  output int          fails,
  output int          outstanding
);

  typedef struct {
    outcome_t   outcome;
    logic       mode;
    logic [1:0] ready;
    logic [1:0] pending;
    logic       nexus;
    logic [3:0] count;
  } table_status_t;

  typedef struct {
    logic              used;
    logic [PID_W-1:0]  pid;
    logic [SLOT_W-1:0] slot;
  } map_row_t;

  map_row_t         pid_map      [PID_SLOTS];
  logic             slot_open    [KEY_SLOTS];
  logic [1:0]       ready_bits   [KEY_SLOTS];
  logic [1:0]       pending_bits [KEY_SLOTS];
  logic [KEY_W-1:0] even_word    [KEY_SLOTS];
  logic [KEY_W-1:0] odd_word     [KEY_SLOTS];
  logic             scramble_on;
  logic             nexus_seen;
  table_status_t    expected_status [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    fails++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic int find_pid_row(input logic [PID_W-1:0] pid);
    for (int i = 0; i < PID_SLOTS; i++) begin
      if (pid_map[i].used && pid_map[i].pid == pid) return i;
    end
    return -1;
  endfunction

  function automatic bit slot_in_map(input logic [SLOT_W-1:0] slot);
    for (int i = 0; i < PID_SLOTS; i++) begin
      if (pid_map[i].used && pid_map[i].slot == slot) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int rows_in_use();
    int n;
    n = 0;
    foreach (pid_map[i]) begin
      if (pid_map[i].used) n++;
    end
    return n;
  endfunction

  function automatic table_status_t apply_command(input logic [2:0] cmd,
                                                  input logic [5:0] slot_raw,
                                                  input logic [PID_W-1:0] pid,
                                                  input logic [KEY_W-1:0] key);
    table_status_t     st;
    logic              have_slot;
    logic [SLOT_W-1:0] slot;
    int                row;
    int                used;
    st.outcome = OUT_IGNORED;
    have_slot  = (slot_raw < KEY_SLOTS);
    slot       = slot_raw[SLOT_W-1:0];
    if (have_slot) begin
      case (cmd)
        CMD_INVALIDATE: begin
          scramble_on = 1'b0;
          foreach (slot_open[i]) slot_open[i] = 1'b0;
          foreach (pid_map[i]) pid_map[i].used = 1'b0;
          st.outcome = OUT_APPLIED;
        end
        CMD_ADD_PID: begin
          if (find_pid_row(pid) < 0) begin
            row = -1;
            for (int i = PID_SLOTS - 1; i >= 0; i--) begin
              if (!pid_map[i].used) row = i;
            end
            if (row < 0) begin
              st.outcome = OUT_MAP_FULL;
            end else begin
              if (!slot_open[slot]) begin
                slot_open[slot]    = 1'b1;
                ready_bits[slot]   = 2'b00;
                pending_bits[slot] = 2'b00;
              end
              pid_map[row] = '{1'b1, pid, slot};
              st.outcome   = OUT_APPLIED;
            end
          end
        end
        CMD_CLOSE_PID: begin
          row = find_pid_row(pid);
          if (row >= 0) begin
            slot              = pid_map[row].slot;
            pid_map[row].used = 1'b0;
            if (!slot_in_map(slot)) begin
              ready_bits[slot] = 2'b00;
              if (rows_in_use() == 0) scramble_on = 1'b0;
            end
            st.outcome = OUT_APPLIED;
          end
        end
        CMD_EVEN_KEY, CMD_ODD_KEY, CMD_NEXUS: begin
          if (slot_in_map(slot)) begin
            if (cmd == CMD_NEXUS) begin
              nexus_seen  = 1'b1;
              scramble_on = 1'b1;
            end else begin
              if (cmd == CMD_EVEN_KEY) begin
                even_word[slot]    = key;
                ready_bits[slot]   = ready_bits[slot] | BIT_EVEN;
                pending_bits[slot] = pending_bits[slot] | BIT_EVEN;
              end else begin
                odd_word[slot]     = key;
                ready_bits[slot]   = ready_bits[slot] | BIT_ODD;
                pending_bits[slot] = pending_bits[slot] | BIT_ODD;
              end
              if (!scramble_on && ready_bits[slot] == BOTH_READY) scramble_on = 1'b1;
            end
            st.outcome = OUT_APPLIED;
          end
        end
        default: ;
      endcase
    end
    used       = rows_in_use();
    st.mode    = scramble_on;
    st.ready   = have_slot ? ready_bits[slot] : 2'b00;
    st.pending = have_slot ? pending_bits[slot] : 2'b00;
    st.nexus   = nexus_seen;
    st.count   = (used > 15) ? 4'd15 : 4'(used);
    return st;
  endfunction

  always @(posedge clk) begin
    table_status_t want;
    if (rst) begin
      foreach (pid_map[i]) pid_map[i] = '{1'b0, '0, '0};
      foreach (slot_open[i]) begin
        slot_open[i]    = 1'b0;
        ready_bits[i]   = 2'b00;
        pending_bits[i] = 2'b00;
      end
      scramble_on = 1'b0;
      nexus_seen  = 1'b0;
      expected_status.delete();
    end else begin
      // results first: a result never belongs to the command taken at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%04h with none expected", m_tdata));
        end else begin
          want = expected_status.pop_front();
          check_field("outcome", m_tdata[1:0], want.outcome);
          check_field("scramble_mode", m_tdata[2], want.mode);
          check_field("slot_ready_bits", m_tdata[4:3], want.ready);
          check_field("slot_pending_bits", m_tdata[6:5], want.pending);
          check_field("nexus_flag", m_tdata[7], want.nexus);
          check_field("mapped_pid_count", m_tdata[11:8], want.count);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_status.push_back(apply_command(s_tuser, s_tdata[5:0], s_tdata[18:6],
                                                s_tdata[82:19]));
      end
    end
    outstanding <= expected_status.size();
  end

endmodule

### verif/tb_descrambler_key_slot_table.sv
`timescale 1ns / 1ps
// tb_descrambler_key_slot_table: command stimulus and verdict for the key slot table
// directed corner beats, then random command mixes under varying idle and stall rates
// depends on dkst_pkg, descrambler_key_slot_table and dkst_checker
module tb_descrambler_key_slot_table;
  import dkst_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASE_ITEMS    = 270;
  localparam int POOL_SIZE      = 12;

  localparam logic [2:0] CMD_RSVD_A     = 3'd6;
  localparam logic [2:0] CMD_RSVD_B     = 3'd7;
  localparam logic [5:0] SLOT_MINUS_ONE = 6'h3F;
  localparam logic [5:0] SLOT_PAST_END  = 6'd16;
  localparam logic [5:0] SLOT_MOST_NEG  = 6'h20;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  int          fails;
  int          outstanding;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  int          idle_cycles = 0;
  logic [PID_W-1:0] pid_pool [POOL_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  descrambler_key_slot_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dkst_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fails       (fails),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("descrambler_key_slot_table regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [5:0] slot,
                              input logic [PID_W-1:0] pid, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'd0, key, pid, slot};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_command();
    int               r;
    logic [2:0]       cmd;
    logic [5:0]       slot;
    logic [PID_W-1:0] pid;
    r = $urandom_range(99);
    if (r < 30) cmd = CMD_ADD_PID;
    else if (r < 50) cmd = CMD_CLOSE_PID;
    else if (r < 66) cmd = CMD_EVEN_KEY;
    else if (r < 82) cmd = CMD_ODD_KEY;
    else if (r < 90) cmd = CMD_NEXUS;
    else if (r < 93) cmd = CMD_INVALIDATE;
    else cmd = 3'($urandom_range(7));
    r = $urandom_range(99);
    if (r < 60) slot = 6'($urandom_range(3));
    else if (r < 90) slot = 6'($urandom_range(KEY_SLOTS - 1));
    else slot = 6'($urandom);
    if ($urandom_range(99) < 75) pid = pid_pool[$urandom_range(POOL_SIZE - 1)];
    else pid = PID_W'($urandom);
    send_command(cmd, slot, pid, {$urandom, $urandom});
  endtask

  initial begin
    int phase_gap   [4];
    int phase_stall [4];
    phase_gap   = '{0, 79, 0, 26};
    phase_stall = '{0, 0, 79, 26};
    foreach (pid_pool[i]) pid_pool[i] = PID_W'($urandom);
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // nothing mapped yet
    send_command(CMD_EVEN_KEY, 6'd0, '0, '1);
    send_command(CMD_CLOSE_PID, 6'd0, '0, '0);
    send_command(CMD_NEXUS, 6'd0, '0, '0);
    send_command(CMD_ADD_PID, 6'd15, '1, '0);
    send_command(CMD_ADD_PID, 6'd0, '0, '0);
    send_command(CMD_ADD_PID, 6'd3, '0, '1);
    // both keys on one slot
    send_command(CMD_EVEN_KEY, 6'd15, '0, '1);
    send_command(CMD_ODD_KEY, 6'd15, '1, 64'h0123_4567_89AB_CDEF);
    send_command(CMD_RSVD_A, 6'd0, '0, '0);
    send_command(CMD_RSVD_B, 6'd15, '1, '1);
    // slot out of range
    send_command(CMD_ADD_PID, SLOT_MINUS_ONE, 13'd5, '0);
    send_command(CMD_INVALIDATE, SLOT_PAST_END, '0, '0);
    send_command(CMD_EVEN_KEY, SLOT_MOST_NEG, '0, '1);
    // fill the map, the last one overflows
    for (int i = 1; i <= 7; i++) send_command(CMD_ADD_PID, 6'd1, PID_W'(i), '0);
    send_command(CMD_CLOSE_PID, 6'd9, '1, '0);
    send_command(CMD_NEXUS, 6'd1, '0, '0);
    send_command(CMD_INVALIDATE, 6'd0, '0, '0);
    send_command(CMD_CLOSE_PID, 6'd1, 13'd1, '0);
    drain();

    for (int p = 0; p < 4; p++) begin
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      repeat (PHASE_ITEMS) send_random_command();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("descrambler_key_slot_table regression: pass");
    end else begin
      $display("descrambler_key_slot_table regression: fail");
    end
    $finish;
  end

endmodule
